### hdl/bit_to_byte_packer_aligned_top_defines.svh
// Assertion macros for the bit-to-byte packer.
// Included by the top level, which supplies clock and reset in scope.
`ifndef BIT_TO_BYTE_PACKER_ALIGNED_TOP_DEFINES_SVH
`define BIT_TO_BYTE_PACKER_ALIGNED_TOP_DEFINES_SVH

// same-cycle implication
`define B2BPA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b2bpa: same-cycle check failed");

// next-cycle implication
`define B2BPA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b2bpa: next-cycle check failed");

`endif

### hdl/b2bpa_pkg.sv
// Shared types and constants for the bit-to-byte packer.
// No dependencies.
`timescale 1ns / 1ps

package b2bpa_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_CONT = 2'd0;

   localparam logic REG_ALIGN_MODE = 1'b0;
   localparam logic REG_SWAP_BYTES = 1'b1;

   typedef struct packed {
      logic operation;
      logic data_bit;
      logic list_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] align_mode;
      logic       swap_bytes;
   } cfg_type;

   // bytes of one request, byte 0 first in stream order; count is 1..4
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } burst_type;

   typedef struct packed {
      logic [7:0] partial_byte;
      logic [2:0] bits_held;
      logic [1:0] byte_in_word;
   } front_stat_type;

endpackage

### hdl/b2bpa_front.sv
// Front end: accepts requests, packs bits and works out the bytes each request emits.
// Depends on b2bpa_pkg.
`timescale 1ns / 1ps

module b2bpa_front
   import b2bpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            q_full,
   output logic            q_push,
   output burst_type       q_data,
   output front_stat_type  stat
);

   logic [7:0]  partial_ff, partial_in;
   logic [2:0]  bits_ff, bits_in;
   logic [1:0]  biw_ff, biw_in;
   logic [23:0] held_ff, held_in;

   logic        fire;
   logic        word_mode;
   logic [7:0]  pb_shift;
   logic        has_data;
   logic [7:0]  cur_bits;
   logic [3:0]  cur_cnt;
   logic        do_pad;
   logic        real_valid;
   logic [7:0]  real_byte;
   logic [1:0]  biw_after;
   logic [1:0]  zeros;
   logic [2:0]  n_sends;
   logic [3:0][7:0] outs;
   logic [2:0]  out_cnt;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign word_mode = cfg.align_mode[1];

   always_comb begin
      pb_shift   = {partial_ff[6:0], req_payload.data_bit};
      has_data   = !req_payload.operation && (bits_ff == 3'd7);
      cur_bits   = req_payload.operation ? partial_ff : pb_shift;
      if (req_payload.operation) begin
         cur_cnt = {1'b0, bits_ff};
      end else if (has_data) begin
         cur_cnt = 4'd0;
      end else begin
         cur_cnt = {1'b0, bits_ff} + 4'd1;
      end
      do_pad     = req_payload.operation ||
                   (req_payload.list_end && (cfg.align_mode != MODE_CONT));
      real_valid = has_data || (do_pad && (cur_cnt != 4'd0));
      // held bits go to the top of the byte, zeros below
      real_byte  = has_data ? pb_shift : 8'(cur_bits << (4'd8 - cur_cnt));
      biw_after  = biw_ff + {1'b0, real_valid};
      zeros      = (do_pad && word_mode) ? (2'd0 - biw_after) : 2'd0;
      n_sends    = {2'b00, real_valid} + {1'b0, zeros};
   end

   // at most one data byte, then zero padding up to the word boundary
   always_comb begin : l_send
      logic [1:0] biw;
      logic [7:0] b;
      biw     = biw_ff;
      b       = 8'h00;
      held_in = held_ff;
      outs    = '0;
      out_cnt = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < n_sends) begin
            b = ((i == 0) && real_valid) ? real_byte : 8'h00;
            if (word_mode && cfg.swap_bytes) begin
               if (biw == 2'd3) begin
                  outs    = {held_in[7:0], held_in[15:8], held_in[23:16], b};
                  out_cnt = 3'd4;
                  held_in = '0;
               end else begin
                  held_in[{biw, 3'b000} +: 8] = b;
               end
            end else begin
               outs[out_cnt[1:0]] = b;
               out_cnt = out_cnt + 3'd1;
               held_in = '0;
            end
            biw = biw + 2'd1;
         end
      end
      biw_in     = biw;
      partial_in = real_valid ? 8'h00 : cur_bits;
      bits_in    = real_valid ? 3'd0 : cur_cnt[2:0];
   end

   assign q_push       = fire && (out_cnt != 3'd0);
   assign q_data.bytes = outs;
   assign q_data.count = out_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         bits_ff    <= '0;
         biw_ff     <= '0;
         held_ff    <= '0;
      end else if (fire) begin
         partial_ff <= partial_in;
         bits_ff    <= bits_in;
         biw_ff     <= biw_in;
         held_ff    <= held_in;
      end
   end

   assign stat.partial_byte = partial_ff;
   assign stat.bits_held    = bits_ff;
   assign stat.byte_in_word = biw_ff;

endmodule

### hdl/b2bpa_queue.sv
// Short queue of byte bursts between the front and back ends.
// Depends on b2bpa_pkg.
`timescale 1ns / 1ps

module b2bpa_queue
   import b2bpa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output burst_type head_data
);

   burst_type [QUEUE_DEPTH-1:0] mem_ff;
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

### hdl/b2bpa_back.sv
// Back end: walks each burst a byte at a time into the response register.
// Depends on b2bpa_pkg.
`timescale 1ns / 1ps

module b2bpa_back
   import b2bpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  burst_type       head_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            load;
   logic            last;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last = ({1'b0, idx_ff} + 3'd1) == head_data.count;
   assign pop  = load && last;

   always_comb begin
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         idx_in                     = last ? 2'd0 : idx_ff + 2'd1;
         rsp_valid_in               = 1'b1;
         rsp_payload_in.out_byte    = head_data.bytes[idx_ff];
         rsp_payload_in.last_of_run = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### hdl/bit_to_byte_packer_aligned_top.sv
// Bit-to-byte packer with per-list alignment: top level.
// Depends on b2bpa_pkg, b2bpa_front, b2bpa_queue, b2bpa_back and the defines header.
//
// Usage:
//  req_*  : one request per bit (push) or an end-of-stream flush, valid/ready.
//  rsp_*  : packed bytes in stream order, valid/ready; last_of_run marks the
//           final byte a request produced. Requests that emit nothing give no rsp.
//  csr_*  : APB-style registers, align_mode at 0x0 and swap_bytes at 0x4;
//           write only while the block is idle. pready is tied high.
// Timing: a request is taken every cycle while the four-entry burst queue
//  has room. Its first byte reaches rsp through the queue write, then the
//  response register. The response side gives one byte per cycle while
//  rsp_ready is high, so a request that pads out a word (up to four bytes)
//  holds the rsp channel for all of them; the burst queue absorbs this.
// Reset: synchronous, active high; clears registers, packing state and queue.
// Stall: with rsp_ready low the response register holds, the queue fills and
//  req_ready drops once it is full.
`timescale 1ns / 1ps
`include "bit_to_byte_packer_aligned_top_defines.svh"

module bit_to_byte_packer_aligned_top
   import b2bpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   cfg_type        cfg_ff, cfg_in;
   logic           csr_wr;
   logic           q_full;
   logic           q_push;
   burst_type      q_data;
   logic           q_pop;
   logic           q_head_valid;
   burst_type      q_head_data;
   front_stat_type front_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_ALIGN_MODE: cfg_in.align_mode = csr_pwdata[1:0];
            REG_SWAP_BYTES: cfg_in.swap_bytes = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ALIGN_MODE: csr_prdata = {30'd0, cfg_ff.align_mode};
         REG_SWAP_BYTES: csr_prdata = {31'd0, cfg_ff.swap_bytes};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   b2bpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data),
      .stat        (front_stat)
   );

   b2bpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   b2bpa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_data   (q_head_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // no stale bits above an empty partial byte
   `B2BPA_ASSERT_IMP(a_partial_clear, front_stat.bits_held == 3'd0, front_stat.partial_byte == 8'h00)
   // a flush always leaves no bits held
   `B2BPA_ASSERT_NEXT(a_flush_drains, req_valid && req_ready && req_payload.operation, front_stat.bits_held == 3'd0)
   // a flush in word mode ends on a word boundary
   `B2BPA_ASSERT_NEXT(a_flush_aligned, req_valid && req_ready && req_payload.operation && cfg_ff.align_mode[1], front_stat.byte_in_word == 2'd0)
   // a burst is never written into a full queue
   `B2BPA_ASSERT_IMP(a_no_overflow, q_push, !q_full)

endmodule

### dv/bit_to_byte_packer_aligned_top_tb.sv
// Testbench for the bit-to-byte packer: directed alignment and swap cases, then random
// list streams under three idling patterns, checked against an in-bench packing model.
// Depends on b2bpa_pkg and bit_to_byte_packer_aligned_top.
`timescale 1ns / 1ps

module bit_to_byte_packer_aligned_top_tb;
   import b2bpa_pkg::*;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   localparam logic [1:0] MODE_BYTE     = 2'd1;
   localparam logic [1:0] MODE_WORD     = 2'd2;
   localparam logic [1:0] MODE_WORD_ALT = 2'd3;

   localparam logic [2:0] ADDR_ALIGN_MODE = {REG_ALIGN_MODE, 2'b00};
   localparam logic [2:0] ADDR_SWAP_BYTES = {REG_SWAP_BYTES, 2'b00};

   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [2:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   int sender_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // packing model state and register copies
   logic [7:0]  pk_partial = '0;
   logic [3:0]  pk_bits = '0;
   logic [1:0]  pk_pos = '0;
   logic [23:0] pk_held = '0;
   logic [1:0]  cfg_align = MODE_CONT;
   logic        cfg_swap = 1'b0;

   logic [7:0]      run_bytes[$];
   rsp_payload_type expected_bytes_q[$];

   bit_to_byte_packer_aligned_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
   end

   // ---------------------------------------------------------------- packing model

   function automatic void emit_byte(logic [7:0] b);
      if (cfg_align[1] && cfg_swap) begin
         if (pk_pos == 2'd3) begin
            run_bytes.push_back(b);
            run_bytes.push_back(pk_held[23:16]);
            run_bytes.push_back(pk_held[15:8]);
            run_bytes.push_back(pk_held[7:0]);
            pk_held = '0;
         end else begin
            pk_held[8*pk_pos +: 8] = b;
         end
      end else begin
         run_bytes.push_back(b);
         pk_held = '0;
      end
      pk_pos = pk_pos + 2'd1;
   endfunction

   function automatic void pad_to_byte();
      if (pk_bits != 0) begin
         emit_byte(pk_partial << (8 - pk_bits));
         pk_partial = '0;
         pk_bits = '0;
      end
   endfunction

   function automatic void pad_list_end();
      pad_to_byte();
      if (cfg_align[1]) begin
         while (pk_pos != 2'd0) emit_byte(8'h00);
      end
   endfunction

   function automatic void pack_request(req_payload_type r);
      rsp_payload_type e;
      run_bytes.delete();
      if (r.operation == OP_FLUSH) begin
         pad_list_end();
      end else begin
         pk_partial = {pk_partial[6:0], r.data_bit};
         pk_bits = pk_bits + 4'd1;
         if (pk_bits == 4'd8) begin
            emit_byte(pk_partial);
            pk_partial = '0;
            pk_bits = '0;
         end
         if (r.list_end && cfg_align != MODE_CONT) pad_list_end();
      end
      foreach (run_bytes[i]) begin
         e.out_byte = run_bytes[i];
         e.last_of_run = (i == run_bytes.size() - 1);
         expected_bytes_q.push_back(e);
      end
   endfunction

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h last %0b", rsp_payload.out_byte,
                        rsp_payload.last_of_run);
         end else begin
            e = expected_bytes_q.pop_front();
            if (e.out_byte !== rsp_payload.out_byte ||
                e.last_of_run !== rsp_payload.last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                           e.out_byte, e.last_of_run, rsp_payload.out_byte,
                           rsp_payload.last_of_run);
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_request(req_payload_type r);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (!req_ready);
      pack_request(r);
   endtask

   task automatic push_bits(logic [7:0] value, int n, bit end_on_last);
      for (int i = n - 1; i >= 0; i--)
         send_request({OP_PUSH, value[i], end_on_last && i == 0});
   endtask

   // hold requests off until every byte is out, then let the block settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_ALIGN_MODE) cfg_align = data[1:0];
      else if (addr == ADDR_SWAP_BYTES) cfg_swap = data[0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_mode(logic [1:0] mode, logic swap);
      wait_drained();
      csr_write(ADDR_ALIGN_MODE, {30'd0, mode});
      csr_write(ADDR_SWAP_BYTES, {31'd0, swap});
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_byte_alignment();
      // list ending on a byte boundary: no padding byte
      set_mode(MODE_BYTE, 1'b0);
      push_bits(8'hFF, 8, 1'b1);
      // swap outside word mode passes bytes straight through
      set_mode(MODE_BYTE, 1'b1);
      push_bits(8'h05, 3, 1'b1);
   endtask

   task automatic test_continuous_flush();
      set_mode(MODE_CONT, 1'b0);
      // list end ignored in continuous mode
      send_request({OP_PUSH, 1'b1, 1'b1});
      // flush ignores its data and list end fields
      send_request({OP_FLUSH, 1'b1, 1'b1});
      // nothing pending: no byte
      send_request({OP_FLUSH, 1'b0, 1'b0});
   endtask

   task automatic test_word_padding();
      set_mode(MODE_WORD_ALT, 1'b0);
      send_request({OP_PUSH, 1'b0, 1'b1});
      set_mode(MODE_WORD, 1'b0);
      push_bits(8'h03, 2, 1'b0);
      send_request({OP_FLUSH, 1'b0, 1'b1});
   endtask

   task automatic test_swap_mid_word();
      // leave the stream one byte into a word, then turn swapping on
      set_mode(MODE_BYTE, 1'b0);
      send_request({OP_PUSH, 1'b1, 1'b1});
      set_mode(MODE_WORD, 1'b1);
      send_request({OP_PUSH, 1'b1, 1'b1});
      push_bits(8'h02, 2, 1'b0);
      send_request({OP_FLUSH, 1'b0, 1'b0});
   endtask

   task automatic test_random_streams(int req_idle, int rsp_idle, int n_items);
      int sent;
      int len;
      logic [1:0] mode;
      sender_idle_pct = req_idle;
      rsp_idle_pct = rsp_idle;
      for (int seg = 0; seg < 4; seg++) begin
         mode = (seg == 0) ? MODE_CONT : (seg == 3) ? MODE_WORD_ALT
                : 2'($urandom_range(3));
         set_mode(mode, 1'($urandom_range(1)));
         sent = 0;
         while (sent < n_items / 4) begin
            if ($urandom_range(9) == 0) begin
               send_request(3'($urandom_range(7)));
               sent++;
            end else begin
               len = $urandom_range(1, 14);
               for (int i = 0; i < len; i++)
                  send_request({OP_PUSH, 1'($urandom_range(1)), i == len - 1});
               sent += len;
               if ($urandom_range(7) == 0) begin
                  send_request({OP_FLUSH, 1'($urandom_range(1)), 1'($urandom_range(1))});
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      sender_idle_pct = 29;
      rsp_idle_pct = 81;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_byte_alignment();
      test_continuous_flush();
      test_word_padding();
      test_swap_mid_word();
      test_random_streams(29, 81, 100);
      test_random_streams(81, 29, 100);
      test_random_streams(0, 0, 100);

      wait_drained();
      if (mismatches == 0 && expected_bytes_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
